// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define PRDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PRDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/prds_pkg.sv
// Shared types and codes for the parity routed double stack.
// No dependencies.
package prds_pkg;

  localparam int DEPTH_DEF = 32;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_LIST = 2'd2;

  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_VALID    = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic               which_stack;
    logic signed [31:0] item;
    logic               last;
  } out_t;

endpackage

// File: rtl/core/prds_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module prds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/prds_front.sv
// Front end: accepts input transfers, drops unused kinds, queues commands.
// Depends on prds_pkg.
module prds_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  prds_pkg::in_t  in_data,
  output logic           q_valid,
  input  logic           q_pop,
  output prds_pkg::in_t  q_data
);
  import prds_pkg::*;

  in_t        entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       keep;
  logic       push;
  logic       pop;

  // Kind 3 is taken and dropped: it has no results.
  always_comb begin
    unique case (in_data.kind) inside
      KIND_PUSH, KIND_POP, KIND_LIST: keep = 1'b1;
      default:                        keep = 1'b0;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = entries_r[rd_ptr_r];
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

// File: rtl/core/prds_back.sv
// Back end: sequencer over the shared store, fill counters, output register.
// Depends on prds_pkg and prds_ram.
module prds_back #(
  parameter int DEPTH = prds_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  prds_pkg::in_t  q_data,
  output logic           out_valid,
  input  logic           out_ready,
  output prds_pkg::out_t out_data
);
  import prds_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE         = 4'd0;
  localparam logic [3:0] S_PUSH         = 4'd1;
  localparam logic [3:0] S_POP_LO       = 4'd2;
  localparam logic [3:0] S_POP_LO_EMIT  = 4'd3;
  localparam logic [3:0] S_POP_HI       = 4'd4;
  localparam logic [3:0] S_POP_HI_EMIT  = 4'd5;
  localparam logic [3:0] S_LIST_LO      = 4'd6;
  localparam logic [3:0] S_LIST_LO_RD   = 4'd7;
  localparam logic [3:0] S_LIST_LO_EMIT = 4'd8;
  localparam logic [3:0] S_LIST_HI      = 4'd9;
  localparam logic [3:0] S_LIST_HI_RD   = 4'd10;
  localparam logic [3:0] S_LIST_HI_EMIT = 4'd11;

  logic [3:0]        state_r, state_nxt;
  in_t               cmd_r, cmd_nxt;
  logic [FILL_W-1:0] low_r, low_nxt;
  logic [FILL_W-1:0] high_r, high_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic              lastf_r, lastf_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r;
  out_t              res;
  logic              load;
  logic              out_free;
  logic              full;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [31:0]       rd_data;

  prds_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd_r.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || out_ready;
  assign full     = ({1'b0, low_r} + {1'b0, high_r}) >= (FILL_W + 1)'(DEPTH);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    ptr_nxt   = ptr_r;
    lastf_nxt = lastf_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = IDX_W'(low_r);
    rd_en     = 1'b0;
    rd_addr   = ptr_r;
    load      = 1'b0;
    res       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_data;
          unique case (q_data.kind)
            KIND_PUSH: state_nxt = S_PUSH;
            KIND_POP:  state_nxt = S_POP_LO;
            KIND_LIST: state_nxt = S_LIST_LO;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_PUSH: begin
        if (out_free) begin
          load            = 1'b1;
          res.which_stack = cmd_r.value[0];
          res.last        = 1'b1;
          if (full) begin
            res.status = ST_FULL;
          end else begin
            res.status = ST_ACCEPTED;
            wr_en      = 1'b1;
            if (cmd_r.value[0]) begin
              wr_addr  = IDX_W'(FILL_W'(DEPTH - 1) - high_r);
              high_nxt = high_r + 1'b1;
            end else begin
              low_nxt  = low_r + 1'b1;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      S_POP_LO: begin
        if (low_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(low_r - 1'b1);
          low_nxt   = low_r - 1'b1;
          state_nxt = S_POP_LO_EMIT;
        end else if (out_free) begin
          load       = 1'b1;
          res.status = ST_EMPTY;
          state_nxt  = S_POP_HI;
        end
      end
      S_POP_LO_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          res.status = ST_VALID;
          res.item   = rd_data;
          state_nxt  = S_POP_HI;
        end
      end
      S_POP_HI: begin
        if (high_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(FILL_W'(DEPTH) - high_r);
          high_nxt  = high_r - 1'b1;
          state_nxt = S_POP_HI_EMIT;
        end else if (out_free) begin
          load            = 1'b1;
          res.status      = ST_EMPTY;
          res.which_stack = 1'b1;
          res.last        = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_POP_HI_EMIT: begin
        if (out_free) begin
          load            = 1'b1;
          res.status      = ST_VALID;
          res.which_stack = 1'b1;
          res.item        = rd_data;
          res.last        = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_LIST_LO: begin
        if (low_r != '0) begin
          ptr_nxt   = IDX_W'(low_r - 1'b1);
          state_nxt = S_LIST_LO_RD;
        end else if (out_free) begin
          load       = 1'b1;
          res.status = ST_EMPTY;
          state_nxt  = S_LIST_HI;
        end
      end
      S_LIST_LO_RD: begin
        rd_en     = 1'b1;
        lastf_nxt = (ptr_r == '0);
        ptr_nxt   = ptr_r - 1'b1;
        state_nxt = S_LIST_LO_EMIT;
      end
      S_LIST_LO_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          res.status = ST_VALID;
          res.item   = rd_data;
          state_nxt  = lastf_r ? S_LIST_HI : S_LIST_LO_RD;
        end
      end
      S_LIST_HI: begin
        if (high_r != '0) begin
          ptr_nxt   = IDX_W'(FILL_W'(DEPTH) - high_r);
          state_nxt = S_LIST_HI_RD;
        end else if (out_free) begin
          load            = 1'b1;
          res.status      = ST_EMPTY;
          res.which_stack = 1'b1;
          res.last        = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_LIST_HI_RD: begin
        rd_en     = 1'b1;
        lastf_nxt = (ptr_r == IDX_W'(DEPTH - 1));
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_LIST_HI_EMIT;
      end
      S_LIST_HI_EMIT: begin
        if (out_free) begin
          load            = 1'b1;
          res.status      = ST_VALID;
          res.which_stack = 1'b1;
          res.item        = rd_data;
          res.last        = lastf_r;
          state_nxt       = lastf_r ? S_IDLE : S_LIST_HI_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      low_r       <= '0;
      high_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    ptr_r   <= ptr_nxt;
    lastf_r <= lastf_nxt;
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/parity_routed_double_stack_core.sv
// Parity routed double stack: two stacks sharing one store of DEPTH words.
// Usage:
//  - in_valid/in_ready/in_data carry commands: push, pop both, list all.
//    A transfer with an unused kind is taken and gives no results.
//  - out_valid/out_ready/out_data carry results; last marks the final
//    result of a command. Push gives 1 result, pop gives 2, list gives
//    up to DEPTH+1.
//  - A two-entry command queue sits between the front end and the
//    sequencer, so input transfers keep flowing while results stall.
// Sequence:
//  - Push: the sequencer fetches the command from the queue, then loads
//    the result and, unless full, updates the store (fetch plus update).
//  - Pop and list: each stored word takes a store read with a registered
//    output, then the result; an empty stack gives its result with no read.
// Reset (rst_n low, synchronous) empties both stacks and the queue and
// drops any pending result. Store contents need no clearing. When the
// receiver holds out_ready low, the result register holds its value and
// the sequencer waits; the queue then fills and in_ready falls.
// Depends on prds_pkg, prds_front, prds_back, prds_ram.
module parity_routed_double_stack_core #(
  parameter int DEPTH = prds_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  prds_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output prds_pkg::out_t out_data
);
  import prds_pkg::*;

  // Command queue between front end and sequencer.
  logic q_valid;
  logic q_pop;
  in_t  q_data;

  prds_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_data)
  );

  // Sequencer: owns the store, both fill counts and the result register.
  prds_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/prds_chk.sv
// Port-level checker for the parity routed double stack, with its bind.
// Depends on prds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module prds_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input prds_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input prds_pkg::out_t out_data
);
  import prds_pkg::*;

  // A stalled input holds.
  `PRDS_ASSERT(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(in_data), "stalled input changed")

  // A stalled result holds.
  `PRDS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

  // Reset drops any pending result.
  `PRDS_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid, "result pending after reset")

  // Push results are always the only result of their command.
  `PRDS_ASSERT(a_push_last, clk, rst_n, out_valid && (out_data.status == ST_ACCEPTED || out_data.status == ST_FULL) |-> out_data.last, "push result without last")

  // Only valid-value results carry data.
  `PRDS_ASSERT(a_item_zero, clk, rst_n, out_valid && out_data.status != ST_VALID |-> out_data.item == 32'sd0, "nonzero item without data")

endmodule

bind parity_routed_double_stack_core prds_chk u_prds_chk (.*);

// File: bench/tb.sv
// Self-checking bench for parity_routed_double_stack_core: push, pop and list
// commands against an in-bench model of the two stacks that share one store.
// Depends on prds_pkg and the core RTL.
module tb;
  import prds_pkg::*;

  localparam int         DEPTH       = DEPTH_DEF;
  // Kind code the core takes but ignores; the package does not name it
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         LONG_HOLD   = 300;
  localparam int         MAX_PRINTS  = 100;

  // One queued command plus the traffic shaping that goes with it
  typedef struct {
    in_t cmd;
    int  phase;  // 0: sender idles 37%, 1: sender idles 67%, 2: no idling
    bit  drain;  // wait until every result is back before offering this one
    bit  stall;  // receiver holds off for a long stretch once this is loaded
  } cmd_entry_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  cmd_entry_t cmd_q[$];
  out_t       stack_results[$];  // results still owed by the core, oldest first
  int         errors       = 0;
  int         cur_phase    = 0;
  logic       hold_request = 1'b0;
  logic       results_idle = 1'b1;  // registered: nothing owed as of last edge
  int         hold_left    = 0;

  // Stack model: even values grow up from entry 0, odd values down from the top
  logic [31:0] model_store [DEPTH];
  int          even_fill = 0;
  int          odd_fill  = 0;

  parity_routed_double_stack_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Idle percentage per phase; sender and receiver swap rates between phases
  function automatic int idle_percent(input int phase, input bit receiver);
    case (phase)
      0: idle_percent = receiver ? 67 : 37;
      1: idle_percent = receiver ? 37 : 67;
      default: idle_percent = 0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic owe_result(input logic [1:0] status, input logic which,
                            input logic [31:0] item, input logic last);
    out_t r;
    r.status      = status;
    r.which_stack = which;
    r.item        = item;
    r.last        = last;
    stack_results.push_back(r);
  endtask

  // Work out the results of one accepted command and update the stack model
  task automatic predict_stack_results(input in_t cmd);
    logic odd;
    int   i;
    odd = cmd.value[0];
    case (cmd.kind)
      KIND_PUSH: begin
        if (even_fill + odd_fill >= DEPTH) begin
          owe_result(ST_FULL, odd, '0, 1'b1);
        end else begin
          if (!odd) begin
            model_store[even_fill] = cmd.value;
            even_fill++;
          end else begin
            odd_fill++;
            model_store[DEPTH - odd_fill] = cmd.value;
          end
          owe_result(ST_ACCEPTED, odd, '0, 1'b1);
        end
      end
      KIND_POP: begin
        if (even_fill > 0) begin
          even_fill--;
          owe_result(ST_VALID, 1'b0, model_store[even_fill], 1'b0);
        end else begin
          owe_result(ST_EMPTY, 1'b0, '0, 1'b0);
        end
        if (odd_fill > 0) begin
          owe_result(ST_VALID, 1'b1, model_store[DEPTH - odd_fill], 1'b1);
          odd_fill--;
        end else begin
          owe_result(ST_EMPTY, 1'b1, '0, 1'b1);
        end
      end
      KIND_LIST: begin
        // Even stack top first, then odd stack top first; empty marker per stack
        if (even_fill == 0) begin
          owe_result(ST_EMPTY, 1'b0, '0, 1'b0);
        end else begin
          for (i = even_fill - 1; i >= 0; i--)
            owe_result(ST_VALID, 1'b0, model_store[i], 1'b0);
        end
        if (odd_fill == 0) begin
          owe_result(ST_EMPTY, 1'b1, '0, 1'b1);
        end else begin
          for (i = DEPTH - odd_fill; i < DEPTH; i++)
            owe_result(ST_VALID, 1'b1, model_store[i], i == DEPTH - 1);
        end
      end
      default: ;  // unused kind: taken, no results
    endcase
  endtask

  task automatic queue_cmd(input logic [1:0] kind, input logic [31:0] value,
                           input int phase, input bit drain = 1'b0,
                           input bit stall = 1'b0);
    cmd_entry_t e;
    e.cmd.kind  = kind;
    e.cmd.value = value;
    e.phase     = phase;
    e.drain     = drain;
    e.stall     = stall;
    cmd_q.push_back(e);
  endtask

  // Random mix weighted toward pushes so the stacks grow; unused kinds are
  // extra and do not count toward n
  task automatic queue_mixed(input int n, input int phase);
    int done;
    int r;
    done = 0;
    while (done < n) begin
      r = $urandom_range(99);
      if (r < 55) queue_cmd(KIND_PUSH, $urandom(), phase);
      else if (r < 75) queue_cmd(KIND_POP, $urandom(), phase);
      else if (r < 90) queue_cmd(KIND_LIST, $urandom(), phase);
      else queue_cmd(KIND_UNUSED, $urandom(), phase);
      if (r < 90) done++;
    end
  endtask

  // Sender: presents the head of cmd_q, holds it until the transfer
  always @(posedge clk) begin : driver
    logic slot_free;
    logic take;
    slot_free = !in_valid || in_ready;
    take      = 1'b0;
    if (!rst_n) begin
      in_valid     <= 1'b0;
      hold_request <= 1'b0;
    end else begin
      if (slot_free && cmd_q.size() != 0) begin
        // A drain point waits for in_valid low and results_idle so the flag covers the last transfer
        if (cmd_q[0].drain && (in_valid || !results_idle))
          take = 1'b0;
        else
          take = $urandom_range(99) >= idle_percent(cmd_q[0].phase, 1'b0);
      end
      hold_request <= take ? cmd_q[0].stall : 1'b0;
      if (take) begin
        in_valid  <= 1'b1;
        in_data   <= cmd_q[0].cmd;
        cur_phase <= cmd_q[0].phase;
        void'(cmd_q.pop_front());
      end else if (slot_free) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_request) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= $urandom_range(99) >= idle_percent(cur_phase, 1'b1);
    end
  end

  // Monitor: check result transfers first, then predict from the input
  // transfer of the same edge (a result never follows its command that fast)
  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (stack_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d which=%0d item=%h",
                                    out_data.status, out_data.which_stack,
                                    out_data.item));
        end else begin
          want = stack_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, want.status));
          if (out_data.which_stack !== want.which_stack)
            report_mismatch($sformatf("which_stack got %0d want %0d",
                                      out_data.which_stack, want.which_stack));
          if (out_data.item !== want.item)
            report_mismatch($sformatf("item got %h want %h",
                                      out_data.item, want.item));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last got %0d want %0d",
                                      out_data.last, want.last));
        end
      end
      if (in_valid && in_ready) predict_stack_results(in_data);
    end
    results_idle <= stack_results.size() == 0;
  end

  initial begin
    int i;

    // Directed: empty stacks, extreme and negative values, every kind
    queue_cmd(KIND_POP,    $urandom(),    0);
    queue_cmd(KIND_LIST,   $urandom(),    0);
    queue_cmd(KIND_PUSH,   32'h0000_0000, 0);
    queue_cmd(KIND_PUSH,   32'hFFFF_FFFF, 0);  // -1, odd
    queue_cmd(KIND_PUSH,   32'h7FFF_FFFF, 0);
    queue_cmd(KIND_PUSH,   32'h8000_0000, 0);
    queue_cmd(KIND_PUSH,   32'hFFFF_FFFD, 0);  // -3 goes to the odd stack
    queue_cmd(KIND_PUSH,   32'hFFFF_FFFC, 0);  // -4 goes to the even stack
    queue_cmd(KIND_PUSH,   32'h0000_0002, 0);
    queue_cmd(KIND_LIST,   $urandom(),    0);
    queue_cmd(KIND_POP,    $urandom(),    0);
    queue_cmd(KIND_LIST,   $urandom(),    0);
    queue_cmd(KIND_POP,    $urandom(),    0);
    queue_cmd(KIND_POP,    $urandom(),    0);
    queue_cmd(KIND_LIST,   $urandom(),    0);  // odd stack now empty
    queue_cmd(KIND_POP,    $urandom(),    0);
    queue_cmd(KIND_UNUSED, $urandom(),    0);
    queue_cmd(KIND_POP,    $urandom(),    0);  // both empty
    queue_cmd(KIND_PUSH,   32'h0000_0001, 0);
    queue_cmd(KIND_LIST,   $urandom(),    0);  // even stack empty

    queue_mixed(12, 0);

    // Phase 1: settle, empty both stacks, then fill with even values only
    // behind a long receiver hold so the core backs up and drops in_ready
    queue_cmd(KIND_POP, $urandom(), 1, 1'b1);
    for (i = 0; i < 17; i++) queue_cmd(KIND_POP, $urandom(), 1);
    queue_cmd(KIND_PUSH, {$urandom_range(32'hFFFF_FFFF) & 32'hFFFF_FFFE}, 1, 1'b0, 1'b1);
    for (i = 0; i < 32; i++) queue_cmd(KIND_PUSH, $urandom() & 32'hFFFF_FFFE, 1);
    queue_cmd(KIND_LIST, $urandom(), 1);  // longest listing
    for (i = 0; i < 3; i++) queue_cmd(KIND_PUSH, $urandom() | 32'h1, 1);  // full, odd
    queue_cmd(KIND_LIST, $urandom(), 1);

    // Phase 2: no idling; drain the full even stack, then a random mix
    queue_cmd(KIND_POP, $urandom(), 2, 1'b1);
    for (i = 0; i < 31; i++) begin
      queue_cmd(KIND_POP, $urandom(), 2);
      if (i == 15) queue_cmd(KIND_LIST, $urandom(), 2);
    end
    queue_mixed(12, 2);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge, clear of the clocked blocks
    do @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || stack_results.size() != 0);
    repeat (80) @(posedge clk);

    if (errors == 0 && stack_results.size() == 0) begin
      $display("parity_routed_double_stack_core verification clean");
    end else begin
      $display("parity_routed_double_stack_core verification failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #3000000;
    $display("parity_routed_double_stack_core verification failed");
    $finish;
  end

endmodule

// File: parity_routed_double_stack_core.f
+incdir+rtl/core
rtl/core/prds_pkg.sv
rtl/core/prds_ram.sv
rtl/core/prds_front.sv
rtl/core/prds_back.sv
rtl/core/parity_routed_double_stack_core.sv
rtl/core/prds_chk.sv
bench/tb.sv
